### rtl/vml_pkg.sv
// Shared widths, step counts and codes for the vector magnitude limiter.
// No dependencies; imported by every module of the limiter.
`default_nettype none

package vml_pkg;

  localparam int unsigned DATA_W     = 32;  // Q16.16 vector and position parts
  localparam int unsigned LIMIT_W    = 31;  // unsigned Q15.16 limit
  localparam int unsigned KINDS      = 4;   // force, torque, velocity, ang. momentum
  localparam int unsigned RAD_W      = 64;  // sum of three squares
  localparam int unsigned ROOT_W     = 32;  // floor square root of RAD_W bits
  localparam int unsigned REM_W      = ROOT_W + 2;
  localparam int unsigned NUM_W      = 62;  // |v| * limit
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned DIV_STEPS  = DATA_W;

  // Configuration register indexes
  localparam logic [2:0] REG_LOWER_X = 3'd0;
  localparam logic [2:0] REG_LOWER_Y = 3'd1;
  localparam logic [2:0] REG_LOWER_Z = 3'd2;
  localparam logic [2:0] REG_UPPER_X = 3'd3;
  localparam logic [2:0] REG_UPPER_Y = 3'd4;
  localparam logic [2:0] REG_UPPER_Z = 3'd5;

  // Item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_CLAMP = 1'b1;

endpackage

`default_nettype wire

### rtl/vml_isqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on vml_pkg for widths and the step count.
`default_nettype none

module vml_isqrt import vml_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0]  rad_q  [SQRT_STEPS];
  logic [REM_W-1:0]  rem_q  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_q [SQRT_STEPS];
  logic [RAD_W-1:0]  rad_n  [SQRT_STEPS];
  logic [REM_W-1:0]  rem_n  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_n [SQRT_STEPS];

  always_comb begin
    logic [RAD_W-1:0]  rad_c;
    logic [REM_W-1:0]  rem_c;
    logic [ROOT_W-1:0] root_c;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  test;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        rad_c  = rad;
        rem_c  = '0;
        root_c = '0;
      end else begin
        rad_c  = rad_q[k-1];
        rem_c  = rem_q[k-1];
        root_c = root_q[k-1];
      end
      // bring down the next two radicand bits, try subtracting 4q+1
      trial = {rem_c, rad_c[RAD_W-1 -: 2]};
      test  = {2'b00, root_c, 2'b01};
      rad_n[k] = rad_c << 2;
      if (trial >= test) begin
        rem_n[k]  = REM_W'(trial - test);
        root_n[k] = {root_c[ROOT_W-2:0], 1'b1};
      end else begin
        rem_n[k]  = REM_W'(trial);
        root_n[k] = {root_c[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        rad_q[k]  <= rad_n[k];
        rem_q[k]  <= rem_n[k];
        root_q[k] <= root_n[k];
      end
    end
  end

  assign root = root_q[SQRT_STEPS-1];

endmodule

`default_nettype wire

### rtl/vml_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Quotient is known to fit DATA_W bits. Depends on vml_pkg.
`default_nettype none

module vml_div import vml_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [NUM_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic [DATA_W-1:0] quo
);

  logic [ROOT_W-1:0] rem_q [DIV_STEPS];
  logic [DATA_W-1:0] low_q [DIV_STEPS];
  logic [DATA_W-1:0] quo_q [DIV_STEPS];
  logic [ROOT_W-1:0] den_q [DIV_STEPS];
  logic [ROOT_W-1:0] rem_n [DIV_STEPS];
  logic [DATA_W-1:0] low_n [DIV_STEPS];
  logic [DATA_W-1:0] quo_n [DIV_STEPS];
  logic [ROOT_W-1:0] den_n [DIV_STEPS];

  always_comb begin
    logic [ROOT_W-1:0] rem_c;
    logic [DATA_W-1:0] low_c;
    logic [DATA_W-1:0] quo_c;
    logic [ROOT_W-1:0] den_c;
    logic [ROOT_W:0]   trial;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        // upper numerator bits are already below the divisor
        rem_c = ROOT_W'(num[NUM_W-1:DATA_W]);
        low_c = num[DATA_W-1:0];
        quo_c = '0;
        den_c = den;
      end else begin
        rem_c = rem_q[k-1];
        low_c = low_q[k-1];
        quo_c = quo_q[k-1];
        den_c = den_q[k-1];
      end
      trial    = {rem_c, low_c[DATA_W-1]};
      low_n[k] = low_c << 1;
      den_n[k] = den_c;
      if (trial >= {1'b0, den_c}) begin
        rem_n[k] = ROOT_W'(trial - {1'b0, den_c});
        quo_n[k] = {quo_c[DATA_W-2:0], 1'b1};
      end else begin
        rem_n[k] = ROOT_W'(trial);
        quo_n[k] = {quo_c[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_q[k] <= rem_n[k];
        low_q[k] <= low_n[k];
        quo_q[k] <= quo_n[k];
        den_q[k] <= den_n[k];
      end
    end
  end

  assign quo = quo_q[DIV_STEPS-1];

endmodule

`default_nettype wire

### rtl/vector_magnitude_limiter.sv
// Vector magnitude limiter top level: limit table, region test, squares,
// pipelined square root and three pipelined dividers. Uses vml_pkg,
// vml_isqrt and vml_div.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  action kind component pos_* vec_* limit_value
//   out      from block out_valid / out_stall out_x out_y out_z was_clamped was_checked
//   cfg      to block   cfg_we               cfg_index cfg_data
//
// One transaction enters per cycle while in_stall is low; its result reaches the
// output register through 69 register stages: 4 for table read, squares and
// compare (the first loads at the accepting edge), 32 of the root pipeline,
// 32 of the divider pipeline, 1 of output register.
// rst is synchronous: it clears the region registers, all valid bits of the
// limit table and every pipeline valid bit; table contents are not cleared.
// The pipeline advances while the skid register is empty; an output stall
// parks one result in the skid register and then holds in_stall high.
`default_nettype none

module vector_magnitude_limiter import vml_pkg::*; #(
  parameter int unsigned COMPONENTS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  // input transactions
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     action,
  input  logic [1:0]               kind,
  input  logic [3:0]               component,
  input  logic signed [DATA_W-1:0] pos_x,
  input  logic signed [DATA_W-1:0] pos_y,
  input  logic signed [DATA_W-1:0] pos_z,
  input  logic signed [DATA_W-1:0] vec_x,
  input  logic signed [DATA_W-1:0] vec_y,
  input  logic signed [DATA_W-1:0] vec_z,
  input  logic [LIMIT_W-1:0]       limit_value,
  // output transactions
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_x,
  output logic signed [DATA_W-1:0] out_y,
  output logic signed [DATA_W-1:0] out_z,
  output logic                     was_clamped,
  output logic                     was_checked
);

  localparam int unsigned TBL_DEPTH = COMPONENTS * KINDS;
  localparam int unsigned IDX_W     = $clog2(TBL_DEPTH);

  typedef struct packed {
    logic                     act;
    logic                     chk;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic signed [DATA_W-1:0] vz;
  } base_t;

  typedef struct packed {
    base_t            b;
    logic             clp;
    logic [NUM_W-1:0] px;
    logic [NUM_W-1:0] py;
    logic [NUM_W-1:0] pz;
  } root_side_t;

  typedef struct packed {
    base_t b;
    logic  clp;
  } div_side_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic                     clamped;
    logic                     checked;
  } res_t;

  function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
    mag = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
  endfunction

  function automatic logic signed [DATA_W-1:0] apply_sign(input logic neg,
                                                          input logic [DATA_W-1:0] q);
    apply_sign = neg ? DATA_W'(-q) : q;
  endfunction

  // ---------------------------------------------------------------------
  // Region registers
  // ---------------------------------------------------------------------
  logic signed [DATA_W-1:0] lower_x, lower_y, lower_z;
  logic signed [DATA_W-1:0] upper_x, upper_y, upper_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_x <= '0;
      lower_y <= '0;
      lower_z <= '0;
      upper_x <= '0;
      upper_y <= '0;
      upper_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOWER_X: lower_x <= cfg_data;
        REG_LOWER_Y: lower_y <= cfg_data;
        REG_LOWER_Z: lower_z <= cfg_data;
        REG_UPPER_X: upper_x <= cfg_data;
        REG_UPPER_Y: upper_y <= cfg_data;
        REG_UPPER_Z: upper_z <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: advance the whole pipeline while the skid slot is free
  // ---------------------------------------------------------------------
  logic en;
  logic skid_valid;
  logic in_acc;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;
  assign in_acc   = in_valid && en;

  // ---------------------------------------------------------------------
  // Limit table and valid bits
  // ---------------------------------------------------------------------
  logic                 comp_ok;
  logic [IDX_W-1:0]     idx;
  logic                 tbl_wr;
  logic [LIMIT_W-1:0]   limit_table [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] entry_valid;
  logic                 in_box;
  logic                 hit;

  assign comp_ok = 32'(component) < 32'(COMPONENTS);
  assign idx     = IDX_W'({component, kind});
  assign tbl_wr  = in_acc && (action == ACT_LOAD) && comp_ok;
  assign hit     = comp_ok && entry_valid[idx];
  assign in_box  = (pos_x >= lower_x) && (pos_x < upper_x) &&
                   (pos_y >= lower_y) && (pos_y < upper_y) &&
                   (pos_z >= lower_z) && (pos_z < upper_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (tbl_wr) begin
      entry_valid[idx] <= 1'b1;
    end
  end

  // Stage 1: registered table read, magnitudes, region and entry check
  logic               v1;
  base_t              base1;
  logic [DATA_W-1:0]  mag1x, mag1y, mag1z;
  logic [LIMIT_W-1:0] lim1;

  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      limit_table[idx] <= limit_value;
    end
    if (en) begin
      lim1 <= limit_table[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base1.act <= action;
      base1.chk <= (action == ACT_CLAMP) && in_box && hit;
      base1.vx  <= vec_x;
      base1.vy  <= vec_y;
      base1.vz  <= vec_z;
      mag1x     <= mag(vec_x);
      mag1y     <= mag(vec_y);
      mag1z     <= mag(vec_z);
    end
  end

  // Stage 2: squares, squared limit and scaled numerators
  logic             v2;
  base_t            base2;
  logic [RAD_W-1:0] sq2x, sq2y, sq2z, lsq2;
  logic [NUM_W-1:0] prod2x, prod2y, prod2z;

  always_ff @(posedge clk) begin
    if (en) begin
      base2  <= base1;
      sq2x   <= RAD_W'(mag1x) * RAD_W'(mag1x);
      sq2y   <= RAD_W'(mag1y) * RAD_W'(mag1y);
      sq2z   <= RAD_W'(mag1z) * RAD_W'(mag1z);
      lsq2   <= RAD_W'(lim1) * RAD_W'(lim1);
      prod2x <= NUM_W'(mag1x) * NUM_W'(lim1);
      prod2y <= NUM_W'(mag1y) * NUM_W'(lim1);
      prod2z <= NUM_W'(mag1z) * NUM_W'(lim1);
    end
  end

  // Stage 3: squared magnitude
  logic             v3;
  base_t            base3;
  logic [RAD_W-1:0] sum3, lsq3;
  logic [NUM_W-1:0] prod3x, prod3y, prod3z;

  always_ff @(posedge clk) begin
    if (en) begin
      base3  <= base2;
      sum3   <= sq2x + sq2y + sq2z;
      lsq3   <= lsq2;
      prod3x <= prod2x;
      prod3y <= prod2y;
      prod3z <= prod2z;
    end
  end

  // Stage 4: exceed test
  logic             v4;
  root_side_t       side4;
  logic [RAD_W-1:0] sum4;

  always_ff @(posedge clk) begin
    if (en) begin
      side4.b   <= base3;
      side4.clp <= base3.chk && (sum3 > lsq3);
      side4.px  <= prod3x;
      side4.py  <= prod3y;
      side4.pz  <= prod3z;
      sum4      <= sum3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // ---------------------------------------------------------------------
  // Square root with side data carried alongside
  // ---------------------------------------------------------------------
  logic [ROOT_W-1:0]     root;
  logic [ROOT_W-1:0]     den;
  root_side_t            ra_q [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] va;
  root_side_t            ra_last;

  vml_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sum4),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ra_q[0] <= side4;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        ra_q[k] <= ra_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= '0;
    end else if (en) begin
      va <= {va[SQRT_STEPS-2:0], v4};
    end
  end

  assign ra_last = ra_q[SQRT_STEPS-1];
  // a zero root only shows up when nothing is clamped; keep the divider sane
  assign den     = (root == '0) ? ROOT_W'(1) : root;

  // ---------------------------------------------------------------------
  // Three dividers: |v| * limit / root
  // ---------------------------------------------------------------------
  logic [DATA_W-1:0]    qx, qy, qz;
  div_side_t            db_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] vb;
  div_side_t            db_last;

  vml_div u_div_x (.clk(clk), .en(en), .num(ra_last.px), .den(den), .quo(qx));
  vml_div u_div_y (.clk(clk), .en(en), .num(ra_last.py), .den(den), .quo(qy));
  vml_div u_div_z (.clk(clk), .en(en), .num(ra_last.pz), .den(den), .quo(qz));

  always_ff @(posedge clk) begin
    if (en) begin
      db_q[0] <= '{b: ra_last.b, clp: ra_last.clp};
      for (int k = 1; k < DIV_STEPS; k++) begin
        db_q[k] <= db_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (en) begin
      vb <= {vb[DIV_STEPS-2:0], va[SQRT_STEPS-1]};
    end
  end

  assign db_last = db_q[DIV_STEPS-1];

  // ---------------------------------------------------------------------
  // Result selection, output register and skid slot
  // ---------------------------------------------------------------------
  res_t pipe_res;
  res_t out_q;
  res_t skid_q;
  logic out_free;

  always_comb begin
    pipe_res.clamped = db_last.clp;
    pipe_res.checked = db_last.b.chk;
    if (db_last.b.act == ACT_LOAD) begin
      pipe_res.x = '0;
      pipe_res.y = '0;
      pipe_res.z = '0;
    end else if (db_last.clp) begin
      pipe_res.x = apply_sign(db_last.b.vx[DATA_W-1], qx);
      pipe_res.y = apply_sign(db_last.b.vy[DATA_W-1], qy);
      pipe_res.z = apply_sign(db_last.b.vz[DATA_W-1], qz);
    end else begin
      pipe_res.x = db_last.b.vx;
      pipe_res.y = db_last.b.vy;
      pipe_res.z = db_last.b.vz;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        // refill from the skid slot first, else from the pipeline
        out_valid  <= skid_valid || vb[DIV_STEPS-1];
        skid_valid <= 1'b0;
      end else if (en && vb[DIV_STEPS-1]) begin
        // output held: park the emerging result
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_q <= skid_valid ? skid_q : pipe_res;
    end
    if (en && !out_free) begin
      skid_q <= pipe_res;
    end
  end

  assign out_x       = out_q.x;
  assign out_y       = out_q.y;
  assign out_z       = out_q.z;
  assign was_clamped = out_q.clamped;
  assign was_checked = out_q.checked;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds a result while the output register is empty");

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall && vb[DIV_STEPS-1]))
    else $error("skid slot filled without a held output and an emerging result");

  a_clamp_needs_check: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_clamped) |-> was_checked)
    else $error("vector scaled without a region and entry check");

  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    (en && vb[DIV_STEPS-1] && (db_last.b.act == ACT_LOAD)) |->
      (!db_last.b.chk && !db_last.clp))
    else $error("load transaction carries check or clamp flags");

endmodule

`default_nettype wire

### tb/sv/vector_magnitude_limiter_test.sv
// Self-checking testbench for the vector magnitude limiter: random and directed
// load/clamp transactions, region setups and output stalls. Depends on vml_pkg.
`timescale 1ns / 100ps

module vector_magnitude_limiter_test;
  import vml_pkg::*;

  typedef struct {
    logic                     action;
    logic [1:0]               kind;
    logic [3:0]               component;
    logic signed [DATA_W-1:0] px, py, pz, vx, vy, vz;
    logic [LIMIT_W-1:0]       limit;
  } item_t;

  typedef struct {
    logic signed [DATA_W-1:0] x, y, z;
    logic                     clamped, checked;
  } vec_result_t;

  localparam int unsigned NCOMP    = 16;
  localparam int unsigned LATENCY  = 69;
  localparam int unsigned DEPTH    = NCOMP * KINDS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_LOWER_X;
  logic [DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_LOAD;
  logic [1:0] kind = '0;
  logic [3:0] component = '0;
  logic signed [DATA_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [DATA_W-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic [LIMIT_W-1:0] limit_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_x, out_y, out_z;
  logic was_clamped, was_checked;

  vector_magnitude_limiter #(.COMPONENTS(NCOMP)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .kind(kind), .component(component),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .limit_value(limit_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .was_clamped(was_clamped), .was_checked(was_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: region corners and a shadow copy of the limit table
  logic signed [DATA_W-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic [LIMIT_W-1:0] shadow_limit [DEPTH];
  logic               shadow_valid [DEPTH];

  item_t       pending_items[$];
  vec_result_t expected_vectors[$];
  int          error_count = 0;
  int          results_seen = 0;
  int          clamps_seen = 0;
  bit          quiet_tail = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Append one transaction to the stimulus queue
  task automatic queue_item(input item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic logic [31:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] rem, root, bit_v;
    rem = n;
    root = '0;
    bit_v = 64'd1 << 62;
    while (bit_v > rem) bit_v >>= 2;
    while (bit_v != 0) begin
      if (rem >= root + bit_v) begin
        rem = rem - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root[31:0];
  endfunction

  function automatic logic signed [31:0] shrink_part(input logic signed [31:0] v,
      input logic [63:0] lim, input logic [63:0] m);
    logic [63:0] mag, q;
    mag = v < 0 ? 64'(-64'(v)) : 64'(v);
    q = (mag * lim) / m;
    return v < 0 ? -32'(q) : 32'(q);
  endfunction

  // Compute the expected result of one transaction and update the shadow table
  function automatic vec_result_t limit_vector(input item_t it);
    vec_result_t r;
    logic [5:0] idx;
    logic [63:0] ax, ay, az, s, lim, m;
    bit in_box;
    idx = {it.component, it.kind};
    r = '{it.vx, it.vy, it.vz, 1'b0, 1'b0};
    if (it.action == ACT_LOAD) begin
      shadow_limit[idx] = it.limit;
      shadow_valid[idx] = 1'b1;
      r.x = '0; r.y = '0; r.z = '0;
    end else begin
      in_box = it.px >= lo_x && it.px < hi_x && it.py >= lo_y && it.py < hi_y &&
               it.pz >= lo_z && it.pz < hi_z;
      if (in_box && shadow_valid[idx]) begin
        lim = 64'(shadow_limit[idx]);
        ax = it.vx < 0 ? 64'(-64'(it.vx)) : 64'(it.vx);
        ay = it.vy < 0 ? 64'(-64'(it.vy)) : 64'(it.vy);
        az = it.vz < 0 ? 64'(-64'(it.vz)) : 64'(it.vz);
        s = ax * ax + ay * ay + az * az;
        r.checked = 1'b1;
        if (s > lim * lim) begin
          m = 64'(floor_sqrt(s));
          if (m == 0) m = 1;
          r.x = shrink_part(it.vx, lim, m);
          r.y = shrink_part(it.vy, lim, m);
          r.z = shrink_part(it.vz, lim, m);
          r.clamped = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Driver: present the head of the queue, advance on acceptance, idle in bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_vectors.insert(expected_vectors.size(),
                                limit_vector(pending_items.pop_front()));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          // pending_items head is the next transaction after the pop above
          in_valid <= 1'b1;
          action <= pending_items[0].action;
          kind <= pending_items[0].kind;
          component <= pending_items[0].component;
          pos_x <= pending_items[0].px;
          pos_y <= pending_items[0].py;
          pos_z <= pending_items[0].pz;
          vec_x <= pending_items[0].vx;
          vec_y <= pending_items[0].vy;
          vec_z <= pending_items[0].vz;
          limit_value <= pending_items[0].limit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    vec_result_t w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_vectors.size() == 0) begin
          report_mismatch("unexpected result", {out_x, out_y}, '0);
        end else begin
          w = expected_vectors.pop_front();
          if (w.clamped) clamps_seen++;
          if (out_x !== w.x) report_mismatch("out_x", 64'(out_x), 64'(w.x));
          if (out_y !== w.y) report_mismatch("out_y", 64'(out_y), 64'(w.y));
          if (out_z !== w.z) report_mismatch("out_z", 64'(out_z), 64'(w.z));
          if (was_clamped !== w.clamped)
            report_mismatch("was_clamped", 64'(was_clamped), 64'(w.clamped));
          if (was_checked !== w.checked)
            report_mismatch("was_checked", 64'(was_checked), 64'(w.checked));
        end
      end
      // Stall the output in bursts
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [2:0] index, input logic signed [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    case (index)
      REG_LOWER_X: lo_x = value;
      REG_LOWER_Y: lo_y = value;
      REG_LOWER_Z: lo_z = value;
      REG_UPPER_X: hi_x = value;
      REG_UPPER_Y: hi_y = value;
      default:     hi_z = value;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_region(input logic signed [31:0] lx, ly, lz, ux, uy, uz);
    write_reg(REG_LOWER_X, lx);
    write_reg(REG_LOWER_Y, ly);
    write_reg(REG_LOWER_Z, lz);
    write_reg(REG_UPPER_X, ux);
    write_reg(REG_UPPER_Y, uy);
    write_reg(REG_UPPER_Z, uz);
  endtask

  // Hold until everything queued has been checked, then let the pipe drain
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_vectors.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_vec_part(input int shape);
    case (shape)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
      2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic item_t make_item(input logic act, input logic [1:0] k,
      input logic [3:0] c, input logic signed [31:0] p, input logic signed [31:0] x,
      y, z, input logic [30:0] lim);
    item_t it;
    it = '{act, k, c, p, p, p, x, y, z, lim};
    return it;
  endfunction

  // Entries loaded so far by queued items (drives the stimulus only)
  bit queued_loaded [DEPTH];
  function automatic bit shadow_filled(input logic [5:0] idx);
    return queued_loaded[idx];
  endfunction

  // Random phase: mostly clamps inside the region on loaded entries
  task automatic random_phase(input int count, input bit inside_box);
    item_t it;
    int shape;
    repeat (count) begin
      it.action = $urandom_range(0, 5) == 0 ? ACT_LOAD : ACT_CLAMP;
      it.kind = 2'($urandom);
      it.component = 4'($urandom);
      if (inside_box && $urandom_range(0, 9) != 0) begin
        it.px = $signed($urandom_range(0, 32'h0001_ffff)) - 32'sh0001_0000;
        it.py = $signed($urandom_range(0, 32'h0001_ffff)) - 32'sh0001_0000;
        it.pz = $signed($urandom_range(0, 32'h0001_ffff)) - 32'sh0001_0000;
      end else begin
        it.px = $urandom; it.py = $urandom; it.pz = $urandom;
      end
      shape = $urandom_range(0, 3);
      it.vx = rand_vec_part(shape);
      it.vy = rand_vec_part(shape);
      it.vz = rand_vec_part(shape);
      case ($urandom_range(0, 3))
        0: it.limit = 31'($urandom);
        1: it.limit = 31'($urandom_range(0, 3));
        default: it.limit = 31'($urandom_range(0, 32'h0020_0000));
      endcase
      if (it.action == ACT_CLAMP && !shadow_filled({it.component, it.kind}))
        it.action = ACT_LOAD;
      queue_item(it);
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_limit[i] = '0;
      queued_loaded[i] = 1'b0;
    end
    {lo_x, lo_y, lo_z, hi_x, hi_y, hi_z} = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty box after reset: clamp on unloaded entries passes unchanged
    queue_item(make_item(ACT_CLAMP, 2'd0, 4'd0, 0, 32'sh7fff_ffff,
                         32'sh8000_0000, 1, 31'd0));
    queue_item(make_item(ACT_CLAMP, 2'd3, 4'd15, 0, 1, 2, 3, 31'd0));
    drain();

    set_region(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    // Directed: loads with extreme limits, every kind, zero limit, exact limit
    queue_item(make_item(ACT_LOAD, 2'd0, 4'd0, 0, 0, 0, 0, 31'h7fff_ffff));
    queue_item(make_item(ACT_LOAD, 2'd1, 4'd15, 0, 5, 6, 7, 31'd0));
    queue_item(make_item(ACT_LOAD, 2'd2, 4'd7, 0, 0, 0, 0, 31'h0001_0000));
    queue_item(make_item(ACT_LOAD, 2'd3, 4'd8, 0, 0, 0, 0, 31'd1));
    queue_item(make_item(ACT_CLAMP, 2'd0, 4'd0, 32'sh8000_0000,
        32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'd0));
    queue_item(make_item(ACT_CLAMP, 2'd0, 4'd0, 0,
        32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'd0));
    queue_item(make_item(ACT_CLAMP, 2'd1, 4'd15, 0, 1, 0, 0, 31'd0));
    queue_item(make_item(ACT_CLAMP, 2'd1, 4'd15, 0, 0, 0, 0, 31'd0));
    queue_item(make_item(ACT_CLAMP, 2'd2, 4'd7, 0, 32'sh0001_0000, 0, 0, 31'd0));
    queue_item(make_item(ACT_CLAMP, 2'd2, 4'd7, 0,
        32'sh0003_0000, -32'sh0004_0000, 0, 31'd0));
    queue_item(make_item(ACT_CLAMP, 2'd3, 4'd8, 32'sh7fff_fffe,
        -1, 1, -1, 31'd0));
    queue_item(make_item(ACT_CLAMP, 2'd2, 4'd7, 32'sh7fff_ffff,
        32'sh0003_0000, 0, 0, 31'd0));
    queue_item(make_item(ACT_CLAMP, 2'd1, 4'd3, 0, 32'sh0010_0000, 0, 0, 31'd0));
    foreach (pending_items[i])
      if (pending_items[i].action == ACT_LOAD)
        queued_loaded[{pending_items[i].component, pending_items[i].kind}] = 1'b1;
    drain();

    // Random phases over several regions
    for (int k = 0; k < DEPTH; k++) queued_loaded[k] = shadow_valid[k];
    set_region(-32'sh0000_8000, -32'sh0000_8000, -32'sh0000_8000,
               32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);
    random_phase(350, 1'b1);
    foreach (pending_items[i])
      if (pending_items[i].action == ACT_LOAD)
        queued_loaded[{pending_items[i].component, pending_items[i].kind}] = 1'b1;
    drain();
    set_region(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    random_phase(350, 1'b1);
    foreach (pending_items[i])
      if (pending_items[i].action == ACT_LOAD)
        queued_loaded[{pending_items[i].component, pending_items[i].kind}] = 1'b1;
    drain();
    // Inverted box: nothing is inside
    set_region(32'sh0001_0000, 0, 0, -32'sh0001_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
    random_phase(150, 1'b1);
    drain();
    // Last part with no idling on either side
    set_region(-32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000,
               32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    quiet_tail = 1'b1;
    random_phase(280, 1'b1);
    drain();

    $display("Checked %0d results, %0d of them scaled down, over six region setups.",
             results_seen, clamps_seen);
    if (error_count == 0) begin
      $display("vector_magnitude_limiter_test: clean");
    end else begin
      $display("vector_magnitude_limiter_test: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("vector_magnitude_limiter_test: errors");
    $finish;
  end

endmodule
